[rtl/dpl_pkg.sv]
// Package for the dual pump level controller.
// Holds the configuration record, channel status record, register indexes and reset values.
// Used by every module of the block; it depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package dpl_pkg;

	// Register indexes on the configuration port.
	localparam logic [1:0] REG_DRY_RUN_TIMEOUT = 2'd0;
	localparam logic [1:0] REG_BLINK_HALF      = 2'd1;
	localparam logic [1:0] REG_HEARTBEAT       = 2'd2;
	localparam logic [1:0] REG_REBOOT_LIMIT    = 2'd3;

	localparam int CFG_DATA_W = 16;
	localparam int RUN_W      = 16;
	localparam int BLINK_W    = 12;
	localparam int BEAT_W     = 10;
	localparam int IDLE_W     = 16;

	// Register values after reset.
	localparam logic [RUN_W-1:0]   RST_DRY_RUN_TIMEOUT = 16'd10000;
	localparam logic [BLINK_W-1:0] RST_BLINK_HALF      = 12'd500;
	localparam logic [BEAT_W-1:0]  RST_HEARTBEAT       = 10'd100;
	localparam logic [IDLE_W-1:0]  RST_REBOOT_LIMIT    = 16'd3000;

	// Configuration registers as one record.
	typedef struct packed {
		logic [RUN_W-1:0]   dry_run_timeout_ms;
		logic [BLINK_W-1:0] blink_half_period_ms;
		logic [BEAT_W-1:0]  heartbeat_period_ms;
		logic [IDLE_W-1:0]  reboot_limit;
	} cfg_t;

	// What one pump channel reports.
	typedef struct packed {
		logic running;
		logic led;
	} chan_status_t;

endpackage

`default_nettype wire

[rtl/dpl_channel.sv]
// One pump channel: hysteresis demand, dry-run timeout with fault latch, blinking error LED.
// Depends on dpl_pkg for the configuration and status records.
`timescale 1ns / 1ps
`default_nettype none

module dpl_channel (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  advance,
	input  wire logic                  soft_reset,
	input  wire logic                  start_sw_n,
	input  wire logic                  stop_sw_n,
	input  wire dpl_pkg::cfg_t         cfg,
	output dpl_pkg::chan_status_t      cur,
	output dpl_pkg::chan_status_t      nxt
);

	logic                         running_q, fault_q, led_q;
	logic [dpl_pkg::RUN_W-1:0]    run_timer_q;
	logic [dpl_pkg::BLINK_W-1:0]  blink_timer_q;

	logic                         running_d, fault_d, led_d;
	logic [dpl_pkg::RUN_W-1:0]    run_timer_d;
	logic [dpl_pkg::BLINK_W-1:0]  blink_timer_d;
	logic [dpl_pkg::BLINK_W-1:0]  blink_inc;
	logic [dpl_pkg::RUN_W-1:0]    run_inc;
	logic                         start, hold;

	assign start     = !start_sw_n;
	assign hold      = !stop_sw_n;
	assign blink_inc = blink_timer_q + 1'b1;
	assign run_inc   = (run_timer_q == '1) ? run_timer_q : run_timer_q + 1'b1;

	// Next state for one tick.
	always_comb begin
		running_d     = running_q;
		fault_d       = fault_q;
		led_d         = led_q;
		run_timer_d   = run_timer_q;
		blink_timer_d = blink_timer_q;
		if (soft_reset) begin
			running_d     = 1'b0;
			fault_d       = 1'b0;
			led_d         = 1'b0;
			run_timer_d   = '0;
			blink_timer_d = '0;
		end else if (fault_q) begin
			// Faulted: pump stays off, only the LED blinks.
			if (blink_inc >= cfg.blink_half_period_ms) begin
				blink_timer_d = '0;
				led_d         = !led_q;
			end else begin
				blink_timer_d = blink_inc;
			end
		end else if (start || (hold && running_q)) begin
			if (!running_q) begin
				running_d   = 1'b1;
				run_timer_d = '0;
			end else begin
				run_timer_d = run_inc;
				if (start && run_inc >= cfg.dry_run_timeout_ms) begin
					fault_d   = 1'b1;
					running_d = 1'b0;
				end
			end
		end else begin
			running_d = 1'b0;
		end
	end

	// State registers advance once per accepted item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q     <= 1'b0;
			fault_q       <= 1'b0;
			led_q         <= 1'b0;
			run_timer_q   <= '0;
			blink_timer_q <= '0;
		end else if (advance) begin
			running_q     <= running_d;
			fault_q       <= fault_d;
			led_q         <= led_d;
			run_timer_q   <= run_timer_d;
			blink_timer_q <= blink_timer_d;
		end
	end

	assign cur.running = running_q;
	assign cur.led     = led_q;
	assign nxt.running = running_d;
	assign nxt.led     = led_d;

endmodule

`default_nettype wire

[rtl/dpl_heartbeat.sv]
// Heartbeat timer, heartbeat LED level and idle-period counter that triggers the soft reset.
// Depends on dpl_pkg for the configuration record and field widths.
`timescale 1ns / 1ps
`default_nettype none

module dpl_heartbeat (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          advance,
	input  wire logic          pumps_idle,
	input  wire dpl_pkg::cfg_t cfg,
	output logic               soft_reset,
	output logic               beat_level_d
);

	logic [dpl_pkg::BEAT_W-1:0] beat_timer_q, beat_timer_d, beat_inc;
	logic [dpl_pkg::IDLE_W-1:0] idle_periods_q, idle_periods_d;
	logic                       beat_level_q;
	logic                       period_end;

	assign beat_inc   = beat_timer_q + 1'b1;
	assign period_end = beat_inc >= cfg.heartbeat_period_ms;
	assign soft_reset = period_end && (idle_periods_q >= cfg.reboot_limit);

	// Next state; pump states seen here are those left by the previous item.
	always_comb begin
		beat_timer_d   = beat_inc;
		idle_periods_d = idle_periods_q;
		beat_level_d   = beat_level_q;
		if (soft_reset) begin
			beat_timer_d   = '0;
			idle_periods_d = '0;
			beat_level_d   = 1'b0;
		end else if (period_end) begin
			beat_timer_d = '0;
			beat_level_d = !beat_level_q;
			if (pumps_idle) begin
				idle_periods_d = idle_periods_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_timer_q   <= '0;
			idle_periods_q <= '0;
			beat_level_q   <= 1'b0;
		end else if (advance) begin
			beat_timer_q   <= beat_timer_d;
			idle_periods_q <= idle_periods_d;
			beat_level_q   <= beat_level_d;
		end
	end

endmodule

`default_nettype wire

[rtl/dual_pump_level_controller.sv]
// Dual pump level controller, one input item per millisecond tick.
// An accepted item's result is in the output register in the cycle after it is accepted.
// Throughput: one item per cycle; while a finished result is stalled the input is stalled too.
// Reset: arst_n clears all state and the output register and loads the default registers.
// Depends on dpl_pkg, dpl_channel and dpl_heartbeat.
`timescale 1ns / 1ps
`default_nettype none

module dual_pump_level_controller (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [1:0]                     cfg_index,
	input  wire logic [dpl_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic                           start_sw_a_n,
	input  wire logic                           stop_sw_a_n,
	input  wire logic                           start_sw_b_n,
	input  wire logic                           stop_sw_b_n,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic                                pump_a_on,
	output logic                                pump_b_on,
	output logic                                error_led_a,
	output logic                                error_led_b,
	output logic                                heartbeat_led,
	output logic                                soft_reset_pulse
);

	dpl_pkg::cfg_t         cfg_q;
	dpl_pkg::chan_status_t cur_a, cur_b, nxt_a, nxt_b;
	logic                  accept, soft_reset, beat_level_d;

	// Input is held only while a finished result is stalled.
	assign in_stall = out_valid && out_stall;
	assign accept   = in_valid && !in_stall;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dry_run_timeout_ms   <= dpl_pkg::RST_DRY_RUN_TIMEOUT;
			cfg_q.blink_half_period_ms <= dpl_pkg::RST_BLINK_HALF;
			cfg_q.heartbeat_period_ms  <= dpl_pkg::RST_HEARTBEAT;
			cfg_q.reboot_limit         <= dpl_pkg::RST_REBOOT_LIMIT;
		end else if (cfg_we) begin
			case (cfg_index)
				dpl_pkg::REG_DRY_RUN_TIMEOUT: begin
					cfg_q.dry_run_timeout_ms <= cfg_data[dpl_pkg::RUN_W-1:0];
				end
				dpl_pkg::REG_BLINK_HALF: begin
					cfg_q.blink_half_period_ms <= cfg_data[dpl_pkg::BLINK_W-1:0];
				end
				dpl_pkg::REG_HEARTBEAT: begin
					cfg_q.heartbeat_period_ms <= cfg_data[dpl_pkg::BEAT_W-1:0];
				end
				dpl_pkg::REG_REBOOT_LIMIT: begin
					cfg_q.reboot_limit <= cfg_data[dpl_pkg::IDLE_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Heartbeat and soft reset decision.
	dpl_heartbeat u_beat (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (accept),
		.pumps_idle   (!cur_a.running && !cur_b.running),
		.cfg          (cfg_q),
		.soft_reset   (soft_reset),
		.beat_level_d (beat_level_d)
	);

	// The two pump channels.
	dpl_channel u_chan_a (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (accept),
		.soft_reset (soft_reset),
		.start_sw_n (start_sw_a_n),
		.stop_sw_n  (stop_sw_a_n),
		.cfg        (cfg_q),
		.cur        (cur_a),
		.nxt        (nxt_a)
	);

	dpl_channel u_chan_b (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (accept),
		.soft_reset (soft_reset),
		.start_sw_n (start_sw_b_n),
		.stop_sw_n  (stop_sw_b_n),
		.cfg        (cfg_q),
		.cur        (cur_b),
		.nxt        (nxt_b)
	);

	// Output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (accept) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	// Result register; a soft reset leaves every state zero, so the item reads all zero but for soft_reset_pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pump_a_on        <= 1'b0;
			pump_b_on        <= 1'b0;
			error_led_a      <= 1'b0;
			error_led_b      <= 1'b0;
			heartbeat_led    <= 1'b0;
			soft_reset_pulse <= 1'b0;
		end else if (accept) begin
			pump_a_on        <= nxt_a.running;
			pump_b_on        <= nxt_b.running;
			error_led_a      <= nxt_a.led;
			error_led_b      <= nxt_b.led;
			heartbeat_led    <= beat_level_d;
			soft_reset_pulse <= soft_reset;
		end
	end

`ifndef ASSERT_OFF
	a_stall_needs_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with no result pending");

	a_accept_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid)
		else $error("accepted item produced no result");

	a_soft_reset_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && soft_reset_pulse) |-> (!pump_a_on && !pump_b_on &&
		!error_led_a && !error_led_b && !heartbeat_led))
		else $error("soft reset result not all zero");

	a_fault_a_pump_off: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && error_led_a) |-> !pump_a_on)
		else $error("channel A pump runs while its error LED is lit");

	a_fault_b_pump_off: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && error_led_b) |-> !pump_b_on)
		else $error("channel B pump runs while its error LED is lit");
`endif

endmodule

`default_nettype wire

[bench/tb.sv]
// Self-checking bench for the dual pump level controller.
// A cycle-level predictor of both pump channels, the heartbeat and the reboot counter
// checks every tick result. Depends on dpl_pkg and the RTL top level only.
`timescale 1ns / 1ps

module tb;

	localparam int CFG_W = dpl_pkg::CFG_DATA_W;

	// Expected view of one tick result.
	typedef struct packed {
		logic pump_a;
		logic pump_b;
		logic led_a;
		logic led_b;
		logic beat;
		logic soft_reset;
	} tick_outputs_t;

	// State of one pump channel in the predictor.
	typedef struct packed {
		logic                        running;
		logic                        fault;
		logic [dpl_pkg::RUN_W-1:0]   run_timer;
		logic [dpl_pkg::BLINK_W-1:0] blink_timer;
		logic                        led;
	} pump_channel_t;

	// Tank level that a switch pair is made to report.
	typedef enum int {LEVEL_LOW, LEVEL_MID, LEVEL_HIGH, LEVEL_NOISE} level_mode_t;

	logic clk;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = dpl_pkg::REG_DRY_RUN_TIMEOUT;
	logic [CFG_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic start_sw_a_n = 1'b1;
	logic stop_sw_a_n = 1'b1;
	logic start_sw_b_n = 1'b1;
	logic stop_sw_b_n = 1'b1;
	logic out_valid;
	logic out_stall = 1'b0;
	logic pump_a_on;
	logic pump_b_on;
	logic error_led_a;
	logic error_led_b;
	logic heartbeat_led;
	logic soft_reset_pulse;

	dual_pump_level_controller u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.start_sw_a_n     (start_sw_a_n),
		.stop_sw_a_n      (stop_sw_a_n),
		.start_sw_b_n     (start_sw_b_n),
		.stop_sw_b_n      (stop_sw_b_n),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.pump_a_on        (pump_a_on),
		.pump_b_on        (pump_b_on),
		.error_led_a      (error_led_a),
		.error_led_b      (error_led_b),
		.heartbeat_led    (heartbeat_led),
		.soft_reset_pulse (soft_reset_pulse)
	);

	// Predictor state and register copy.
	dpl_pkg::cfg_t              regs;
	pump_channel_t              chan_a;
	pump_channel_t              chan_b;
	logic [dpl_pkg::BEAT_W-1:0] beat_timer;
	logic                       beat_level;
	logic [dpl_pkg::IDLE_W-1:0] idle_periods;

	tick_outputs_t pending_outputs[$];
	logic [3:0]    switch_plan[$];

	int  mismatches = 0;
	int  ticks_sent = 0;
	int  results_checked = 0;
	int  settings_used = 0;
	int  faults_predicted = 0;
	int  soft_resets_predicted = 0;
	bit  tx_idling = 1'b0;
	bit  rx_idling = 1'b0;
	int  long_hold_left = 0;
	int  burst_left = 0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Everything but the registers returns to zero, as on a soft reset.
	function automatic void clear_pump_state();
		chan_a = '0;
		chan_b = '0;
		beat_timer = '0;
		beat_level = 1'b0;
		idle_periods = '0;
	endfunction

	// One channel for one tick: blink while faulted, else hysteresis with dry-run check.
	function automatic pump_channel_t next_channel(input pump_channel_t ch, input logic start,
	                                               input logic hold);
		if (ch.fault) begin
			ch.blink_timer = ch.blink_timer + 1'b1;
			if (ch.blink_timer >= regs.blink_half_period_ms) begin
				ch.blink_timer = '0;
				ch.led = ~ch.led;
			end
			return ch;
		end
		if (start || (hold && ch.running)) begin
			if (!ch.running) begin
				ch.running = 1'b1;
				ch.run_timer = '0;
			end else begin
				if (ch.run_timer != '1)
					ch.run_timer = ch.run_timer + 1'b1;
				if (start && ch.run_timer >= regs.dry_run_timeout_ms) begin
					ch.fault = 1'b1;
					ch.running = 1'b0;
					faults_predicted++;
				end
			end
		end else begin
			ch.running = 1'b0;
		end
		return ch;
	endfunction

	// Advances the predictor by one tick; sw is {start_a_n, stop_a_n, start_b_n, stop_b_n}.
	function automatic tick_outputs_t predict_tick(input logic [3:0] sw);
		tick_outputs_t res;
		res = '0;
		beat_timer = beat_timer + 1'b1;
		if (beat_timer >= regs.heartbeat_period_ms) begin
			beat_timer = '0;
			if (idle_periods >= regs.reboot_limit) begin
				clear_pump_state();
				soft_resets_predicted++;
				res.soft_reset = 1'b1;
				return res;
			end
			if (!chan_a.running && !chan_b.running)
				idle_periods = idle_periods + 1'b1;
			beat_level = ~beat_level;
		end
		chan_a = next_channel(chan_a, !sw[3], !sw[2]);
		chan_b = next_channel(chan_b, !sw[1], !sw[0]);
		res.pump_a = chan_a.running;
		res.pump_b = chan_b.running;
		res.led_a = chan_a.led;
		res.led_b = chan_b.led;
		res.beat = beat_level;
		return res;
	endfunction

	task automatic report_mismatch(input string what);
		mismatches++;
		$display("MISMATCH at result %0d: %s", results_checked, what);
	endtask

	task automatic check_bit(input string name, input logic got, input logic want);
		if (got !== want)
			report_mismatch($sformatf("%s is %b, expected %b", name, got, want));
	endtask

	// Result checker: every accepted result against the oldest expectation.
	initial begin
		tick_outputs_t want;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				if (pending_outputs.size() == 0) begin
					report_mismatch("result with no item waiting for it");
				end else begin
					want = pending_outputs.pop_front();
					check_bit("pump_a_on", pump_a_on, want.pump_a);
					check_bit("pump_b_on", pump_b_on, want.pump_b);
					check_bit("error_led_a", error_led_a, want.led_a);
					check_bit("error_led_b", error_led_b, want.led_b);
					check_bit("heartbeat_led", heartbeat_led, want.beat);
					check_bit("soft_reset_pulse", soft_reset_pulse, want.soft_reset);
				end
				results_checked++;
			end
		end
	end

	// Receiver stall: a long hold when asked for, otherwise random bursts while rx_idling is set.
	initial begin
		forever begin
			@(negedge clk);
			if (long_hold_left > 0) begin
				out_stall <= 1'b1;
				long_hold_left = long_hold_left - 1;
			end else if (burst_left > 0) begin
				out_stall <= 1'b1;
				burst_left = burst_left - 1;
			end else if (rx_idling && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				burst_left = $urandom_range(0, 12);
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Sends every planned tick, predicting each one at the edge where it is accepted.
	task automatic send_plan();
		logic [3:0] sw;
		@(negedge clk);
		while (switch_plan.size() != 0) begin
			sw = switch_plan.pop_front();
			if (tx_idling && $urandom_range(0, 4) == 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 13)) @(negedge clk);
			end
			in_valid <= 1'b1;
			{start_sw_a_n, stop_sw_a_n, start_sw_b_n, stop_sw_b_n} <= sw;
			@(posedge clk);
			while (in_stall) @(posedge clk);
			pending_outputs.push_back(predict_tick(sw));
			ticks_sent++;
			@(negedge clk);
		end
		in_valid <= 1'b0;
	endtask

	// Waits until every expected result has come, then lets the output stage settle.
	task automatic wait_drained();
		while (pending_outputs.size() != 0) @(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	// Writes all four registers on consecutive cycles while the block is idle.
	task automatic set_config(input logic [dpl_pkg::RUN_W-1:0] timeout,
	                          input logic [dpl_pkg::BLINK_W-1:0] blink,
	                          input logic [dpl_pkg::BEAT_W-1:0] beat,
	                          input logic [dpl_pkg::IDLE_W-1:0] limit);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_index <= dpl_pkg::REG_DRY_RUN_TIMEOUT;
		cfg_data <= CFG_W'(timeout);
		@(negedge clk);
		cfg_index <= dpl_pkg::REG_BLINK_HALF;
		cfg_data <= CFG_W'(blink);
		@(negedge clk);
		cfg_index <= dpl_pkg::REG_HEARTBEAT;
		cfg_data <= CFG_W'(beat);
		@(negedge clk);
		cfg_index <= dpl_pkg::REG_REBOOT_LIMIT;
		cfg_data <= CFG_W'(limit);
		@(negedge clk);
		cfg_we <= 1'b0;
		regs.dry_run_timeout_ms = timeout;
		regs.blink_half_period_ms = blink;
		regs.heartbeat_period_ms = beat;
		regs.reboot_limit = limit;
		settings_used++;
	endtask

	// Plans ticks as runs of tank levels per channel, with some switch noise mixed in.
	task automatic plan_level_runs(input int count);
		level_mode_t mode [2];
		int run_left [2];
		logic [1:0] pair [2];
		int run_max;
		int pick;
		run_max = (regs.dry_run_timeout_ms < 40) ? int'(regs.dry_run_timeout_ms) + 10 : 40;
		run_left[0] = 0;
		run_left[1] = 0;
		mode[0] = LEVEL_HIGH;
		mode[1] = LEVEL_HIGH;
		for (int i = 0; i < count; i++) begin
			for (int c = 0; c < 2; c++) begin
				if (run_left[c] == 0) begin
					pick = $urandom_range(0, 9);
					if (pick < 3)
						mode[c] = LEVEL_LOW;
					else if (pick < 6)
						mode[c] = LEVEL_MID;
					else if (pick < 9)
						mode[c] = LEVEL_HIGH;
					else
						mode[c] = LEVEL_NOISE;
					run_left[c] = $urandom_range(1, run_max);
				end
				run_left[c]--;
				case (mode[c])
					LEVEL_LOW: begin
						pair[c] = 2'b00;
						if ($urandom_range(0, 7) == 0)
							pair[c][0] = 1'b1;
					end
					LEVEL_MID: pair[c] = 2'b10;
					LEVEL_HIGH: pair[c] = 2'b11;
					default: pair[c] = 2'($urandom);
				endcase
			end
			switch_plan.push_back({pair[0], pair[1]});
		end
	endtask

	// A random register setting, mostly small so that faults and soft resets occur.
	task automatic set_random_config();
		logic [dpl_pkg::RUN_W-1:0]   timeout;
		logic [dpl_pkg::BLINK_W-1:0] blink;
		logic [dpl_pkg::BEAT_W-1:0]  beat;
		logic [dpl_pkg::IDLE_W-1:0]  limit;
		timeout = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(1, 65535))
		                                      : 16'($urandom_range(1, 30));
		blink = ($urandom_range(0, 7) == 0) ? 12'($urandom_range(1, 4095))
		                                    : 12'($urandom_range(1, 12));
		beat = ($urandom_range(0, 7) == 0) ? 10'($urandom_range(1, 1023))
		                                   : 10'($urandom_range(1, 12));
		limit = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(1, 65535))
		                                    : 16'($urandom_range(1, 15));
		set_config(timeout, blink, beat, limit);
	endtask

	// Both switch values on every pin, with the reset register values.
	task automatic test_switch_extremes();
		switch_plan.push_back(4'b1111);
		switch_plan.push_back(4'b0000);
		switch_plan.push_back(4'b1010);
		switch_plan.push_back(4'b0101);
		switch_plan.push_back(4'b0011);
		switch_plan.push_back(4'b1100);
		send_plan();
	endtask

	// Dry-run fault on both channels, LED blink, heartbeat and a soft reset.
	task automatic test_dry_run_fault();
		set_config(16'd2, 12'd1, 10'd3, 16'd2);
		repeat (5) switch_plan.push_back(4'b0000);
		repeat (8) switch_plan.push_back(4'b1111);
		send_plan();
	endtask

	// Zero timeout and periods fire every tick; the soft reset still follows the limit.
	task automatic test_zero_registers();
		set_config(16'd0, 12'd0, 10'd0, 16'd3);
		repeat (5) switch_plan.push_back(4'b0000);
		send_plan();
	endtask

	// Largest register values, then all registers at one, under random tank levels.
	task automatic test_register_extremes();
		tx_idling = 1'b1;
		rx_idling = 1'b1;
		set_config(16'd65535, 12'd4095, 10'd1023, 16'd65535);
		plan_level_runs(150);
		send_plan();
		set_config(16'd1, 12'd1, 10'd1, 16'd1);
		plan_level_runs(150);
		send_plan();
	endtask

	// Random settings, each phase with its own idling mix.
	task automatic test_random_phases(input int item_target);
		while (ticks_sent < item_target) begin
			set_random_config();
			tx_idling = ($urandom_range(0, 3) != 0);
			rx_idling = ($urandom_range(0, 3) != 0);
			plan_level_runs($urandom_range(40, 120));
			send_plan();
		end
	endtask

	// Receiver holds off long enough to fill the block; then the sender waits for a drain.
	task automatic test_backpressure();
		set_random_config();
		tx_idling = 1'b0;
		rx_idling = 1'b0;
		long_hold_left = 80;
		plan_level_runs(40);
		send_plan();
		wait_drained();
		tx_idling = 1'b1;
		rx_idling = 1'b1;
		plan_level_runs(40);
		send_plan();
	endtask

	// Full-rate stream at the end of the run, no idling on either side.
	task automatic test_full_rate();
		set_random_config();
		tx_idling = 1'b0;
		rx_idling = 1'b0;
		plan_level_runs(150);
		send_plan();
	endtask

	initial begin
		regs.dry_run_timeout_ms = dpl_pkg::RST_DRY_RUN_TIMEOUT;
		regs.blink_half_period_ms = dpl_pkg::RST_BLINK_HALF;
		regs.heartbeat_period_ms = dpl_pkg::RST_HEARTBEAT;
		regs.reboot_limit = dpl_pkg::RST_REBOOT_LIMIT;
		clear_pump_state();
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		test_switch_extremes();
		test_dry_run_fault();
		test_zero_registers();
		test_register_extremes();
		test_random_phases(1530);
		test_backpressure();
		test_full_rate();

		wait_drained();
		repeat (8) @(negedge clk);
		if (pending_outputs.size() != 0)
			report_mismatch("expected results never arrived");
		$display("Ran %0d ticks over %0d register settings, %0d results checked.",
		         ticks_sent, settings_used, results_checked);
		$display("Predicted %0d dry-run faults and %0d soft resets; %0d mismatches.",
		         faults_predicted, soft_resets_predicted, mismatches);
		if (mismatches == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

	// Run limit, far above the slowest correct run.
	initial begin
		#5_000_000;
		$display("tb failed");
		$finish;
	end

endmodule

[sim.f]
rtl/dpl_pkg.sv
rtl/dpl_channel.sv
rtl/dpl_heartbeat.sv
rtl/dual_pump_level_controller.sv
bench/tb.sv
